### src/dsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsr_pkg: shared types, constants and span math for the disc span rasterizer
// Holds the half-width table, the queue word layout and the per-row span
// function used by both the classifier and the span generator.
// ----------------------------------------------------------------------------
package dsr_pkg;

    // fixed field widths
    localparam int POS_X_W  = 10;
    localparam int POS_Y_W  = 9;
    localparam int TILE_W   = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 6;

    // centre cell widths: (1023 + 4) >> 3 = 128, (511 + 4) >> 3 = 64
    localparam int CX_W     = 8;
    localparam int CY_W     = 7;

    // signed working widths for rows and columns around the centre
    localparam int ROW_SW   = CY_W + 1;
    localparam int COL_SW   = CX_W + 1;

    // disc shape: rows -7 .. +7 around the centre
    localparam int RADIUS   = 7;
    localparam int SPAN_ROWS = 2 * RADIUS + 1;
    localparam int ROW_IDX_W = 4;
    localparam int DIST_W    = 3;
    localparam int HALF_W    = 4;

    localparam logic signed [ROW_SW-1:0] FIRST_ROW = ROW_SW'(2);
    localparam logic signed [COL_SW-1:0] FIRST_COL = COL_SW'(2);

    // word carried from the classifier to the span generator
    typedef struct packed {
        logic [CX_W-1:0]      cx;
        logic [CY_W-1:0]      cy;
        logic [SPAN_ROWS-1:0] mask;
        logic [TILE_W-1:0]    fill;
        logic [TILE_W-1:0]    rim;
    } dsr_word_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } dsr_qstat_t;

    // geometry of one row of the disc
    typedef struct packed {
        logic                     ok;
        logic                     lcut;
        logic                     rcut;
        logic                     outer;
        logic signed [ROW_SW-1:0] row;
        logic signed [COL_SW-1:0] left;
        logic signed [COL_SW-1:0] right;
    } dsr_span_t;

    // half-width of the disc at a given row distance
    function automatic logic [HALF_W-1:0] half_width(input logic [DIST_W-1:0] row_dist);
        logic [HALF_W-1:0] h;
        unique case (row_dist)
            3'd0:    h = 4'd7;
            3'd1:    h = 4'd7;
            3'd2:    h = 4'd7;
            3'd3:    h = 4'd7;
            3'd4:    h = 4'd6;
            3'd5:    h = 4'd6;
            3'd6:    h = 4'd4;
            default: h = 4'd3;
        endcase
        return h;
    endfunction

    // clip one row (index k = d + 7) of the disc against the map
    function automatic dsr_span_t span_of(
        input logic [CX_W-1:0]          cx,
        input logic [CY_W-1:0]          cy,
        input logic [ROW_IDX_W-1:0]     k,
        input logic signed [COL_SW-1:0] cols,
        input logic signed [ROW_SW-1:0] rows
    );
        logic [DIST_W-1:0]        row_dist;
        logic [HALF_W-1:0]        h;
        logic signed [COL_SW-1:0] lft;
        logic signed [COL_SW-1:0] rgt;
        dsr_span_t                s;
        row_dist = (k >= ROW_IDX_W'(RADIUS)) ? DIST_W'(k - ROW_IDX_W'(RADIUS))
                                             : DIST_W'(ROW_IDX_W'(RADIUS) - k);
        h    = half_width(row_dist);
        s.row = $signed({1'b0, cy}) + $signed({{(ROW_SW-ROW_IDX_W){1'b0}}, k})
                - ROW_SW'(RADIUS);
        lft = $signed({1'b0, cx}) - $signed({{(COL_SW-HALF_W){1'b0}}, h});
        rgt = $signed({1'b0, cx}) + $signed({{(COL_SW-HALF_W){1'b0}}, h});
        s.lcut  = lft < FIRST_COL;
        s.rcut  = rgt >= cols;
        s.left  = s.lcut ? FIRST_COL : lft;
        s.right = s.rcut ? (cols - COL_SW'(1)) : rgt;
        s.outer = (row_dist == DIST_W'(RADIUS));
        s.ok    = (s.row >= FIRST_ROW) && (s.row < rows) && (s.right >= s.left);
        return s;
    endfunction

endpackage
`default_nettype wire

### src/dsr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsr_front: command intake and row classification
// Holds the fill tile register, takes a command, finds the centre cell and
// marks which of the fifteen disc rows survive clipping.
// ----------------------------------------------------------------------------
module dsr_front
    import dsr_pkg::*;
#(
    parameter int MAP_COLUMNS = 40,
    parameter int MAP_ROWS    = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [POS_X_W-1:0] pos_x,
    input  wire logic [POS_Y_W-1:0] pos_y,
    input  wire logic               active,
    input  wire logic               cfg_we,
    input  wire logic [TILE_W-1:0]  cfg_wdata,
    input  wire dsr_qstat_t         qstat,
    output logic                    busy,
    output logic                    push,
    output dsr_word_t               word
);

    localparam logic signed [COL_SW-1:0] COLS = COL_SW'(MAP_COLUMNS);
    localparam logic signed [ROW_SW-1:0] ROWS = ROW_SW'(MAP_ROWS);

    logic [TILE_W-1:0] laser_tile_reg;
    logic [TILE_W-1:0] laser_tile_next;
    dsr_span_t         probe [SPAN_ROWS];

    // hold the fill tile until a new write arrives
    always_comb
    begin
        laser_tile_next = cfg_we ? cfg_wdata : laser_tile_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            laser_tile_reg <= '0;
        end
        else
        begin
            laser_tile_reg <= laser_tile_next;
        end
    end

    // accept a command while the queue has room
    assign busy = qstat.full;
    assign push = start && !qstat.full;

    // round the position to the cell centre, pick the tiles
    always_comb
    begin
        word.cx   = CX_W'((11'(pos_x) + 11'd4) >> 3);
        word.cy   = CY_W'((10'(pos_y) + 10'd4) >> 3);
        word.fill = active ? laser_tile_reg : '0;
        word.rim  = active ? (laser_tile_reg + TILE_W'(1)) : '0;
        for (int i = 0; i < SPAN_ROWS; i++)
        begin
            probe[i]     = span_of(word.cx, word.cy, ROW_IDX_W'(i), COLS, ROWS);
            word.mask[i] = probe[i].ok;
        end
    end

endmodule
`default_nettype wire

### src/dsr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsr_queue: two-entry command queue
// Decouples the classifier from the span generator so that a new command can
// be taken while the previous one is still being drawn.
// ----------------------------------------------------------------------------
module dsr_queue
    import dsr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire dsr_word_t push_word,
    input  wire logic      pop,
    output dsr_qstat_t     qstat,
    output dsr_word_t      head
);

    dsr_word_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign qstat.full      = (count_reg == 2'd2);
    assign qstat.not_empty = (count_reg != 2'd0);
    assign head            = mem_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

### src/dsr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsr_back: span generator
// Walks the surviving rows of the current command, lowest first, and emits
// one registered span word per cycle with its end and interior tiles.
// ----------------------------------------------------------------------------
module dsr_back
    import dsr_pkg::*;
#(
    parameter int MAP_COLUMNS = 40,
    parameter int MAP_ROWS    = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dsr_qstat_t         qstat,
    input  wire dsr_word_t          head,
    output logic                    pop,
    output logic                    span_strobe,
    output logic [ROW_W-1:0]        row,
    output logic [COL_W-1:0]        first_col,
    output logic [COL_W-1:0]        last_col,
    output logic [TILE_W-1:0]       interior_tile,
    output logic [TILE_W-1:0]       left_tile,
    output logic [TILE_W-1:0]       right_tile,
    output logic                    last
);

    localparam logic signed [COL_SW-1:0] COLS = COL_SW'(MAP_COLUMNS);
    localparam logic signed [ROW_SW-1:0] ROWS = ROW_SW'(MAP_ROWS);

    logic                 cur_valid_reg;
    logic                 cur_valid_next;
    dsr_word_t            cur_reg;
    dsr_word_t            cur_next;
    logic [SPAN_ROWS-1:0] rest;
    logic [ROW_IDX_W-1:0] sel;
    logic                 emit;
    logic                 done;
    dsr_span_t            span;

    logic                 strobe_reg;
    logic                 strobe_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [COL_W-1:0]     first_reg;
    logic [COL_W-1:0]     first_next;
    logic [COL_W-1:0]     lastc_reg;
    logic [COL_W-1:0]     lastc_next;
    logic [TILE_W-1:0]    body_reg;
    logic [TILE_W-1:0]    body_next;
    logic [TILE_W-1:0]    lt_reg;
    logic [TILE_W-1:0]    lt_next;
    logic [TILE_W-1:0]    rt_reg;
    logic [TILE_W-1:0]    rt_next;
    logic                 last_reg;
    logic                 last_next;

    // pick the lowest remaining row
    always_comb
    begin
        sel = '0;
        for (int i = SPAN_ROWS - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
            begin
                sel = ROW_IDX_W'(i);
            end
        end
        rest = cur_reg.mask & (cur_reg.mask - SPAN_ROWS'(1));
        span = span_of(cur_reg.cx, cur_reg.cy, sel, COLS, ROWS);
    end

    // advance through rows, load the next command when this one is drained
    always_comb
    begin
        emit = cur_valid_reg && (cur_reg.mask != '0);
        done = !cur_valid_reg || (rest == '0);
        pop  = done && qstat.not_empty;

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_next       = head;
            cur_valid_next = 1'b1;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else
        begin
            cur_next.mask = rest;
        end
    end

    // build the span word
    always_comb
    begin
        strobe_next = emit;
        row_next    = span.row[ROW_W-1:0];
        first_next  = span.left[COL_W-1:0];
        lastc_next  = span.right[COL_W-1:0];
        last_next   = (rest == '0);
        if (span.outer)
        begin
            body_next = cur_reg.rim;
            lt_next   = cur_reg.rim;
            rt_next   = cur_reg.rim;
        end
        else
        begin
            body_next = cur_reg.fill;
            lt_next   = span.lcut ? cur_reg.fill : cur_reg.rim;
            rt_next   = span.rcut ? cur_reg.fill : cur_reg.rim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            strobe_reg    <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        row_reg   <= row_next;
        first_reg <= first_next;
        lastc_reg <= lastc_next;
        body_reg  <= body_next;
        lt_reg    <= lt_next;
        rt_reg    <= rt_next;
        last_reg  <= last_next;
    end

    assign span_strobe   = strobe_reg;
    assign row           = row_reg;
    assign first_col     = first_reg;
    assign last_col      = lastc_reg;
    assign interior_tile = body_reg;
    assign left_tile     = lt_reg;
    assign right_tile    = rt_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

### src/disc_span_rasterizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disc_span_rasterizer_top: spans of a filled disc on a tile map
// Turns a disc position into up to fifteen row spans with fill and rim tiles.
// ----------------------------------------------------------------------------
// Usage:
//   Command: drive pos_x, pos_y, active with start high; the word is taken at
//   a clock edge where start is high and busy is low. busy is high while the
//   two-entry command queue is full.
//   Configuration: cfg_we with cfg_wdata writes the fill tile; the rim tile
//   is the next index. Write only while no command is in flight.
//   Result: each span is shown for one cycle with span_strobe high; last
//   marks the final span of a command. A command whose rows all clip away
//   gives no span.
//   Path: an accepted command is written to the queue, loaded into the span
//   generator once it is free, and its spans leave through output registers.
//   Throughput: the span generator emits one span per cycle while a command
//   has rows left, up to fifteen spans per command; the queue lets a new
//   command be taken while the current one is drawn.
//   Reset: rst_n clears the queue, the generator and the fill tile (to 0).
//   The receiver cannot stall: every strobed span must be taken.
// ----------------------------------------------------------------------------
module disc_span_rasterizer_top
    import dsr_pkg::*;
#(
    parameter int MAP_COLUMNS = 40,
    parameter int MAP_ROWS    = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [POS_X_W-1:0] pos_x,
    input  wire logic [POS_Y_W-1:0] pos_y,
    input  wire logic               active,
    input  wire logic               cfg_we,
    input  wire logic [TILE_W-1:0]  cfg_wdata,
    output logic                    span_strobe,
    output logic [ROW_W-1:0]        row,
    output logic [COL_W-1:0]        first_col,
    output logic [COL_W-1:0]        last_col,
    output logic [TILE_W-1:0]       interior_tile,
    output logic [TILE_W-1:0]       left_tile,
    output logic [TILE_W-1:0]       right_tile,
    output logic                    last
);

    dsr_qstat_t qstat;
    dsr_word_t  push_word;
    dsr_word_t  head;
    logic       push;
    logic       pop;

    // classify incoming commands
    dsr_front #(
        .MAP_COLUMNS (MAP_COLUMNS),
        .MAP_ROWS    (MAP_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .active    (active),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .qstat     (qstat),
        .busy      (busy),
        .push      (push),
        .word      (push_word)
    );

    // hold classified commands
    dsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .qstat     (qstat),
        .head      (head)
    );

    // emit spans
    dsr_back #(
        .MAP_COLUMNS (MAP_COLUMNS),
        .MAP_ROWS    (MAP_ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .head          (head),
        .pop           (pop),
        .span_strobe   (span_strobe),
        .row           (row),
        .first_col     (first_col),
        .last_col      (last_col),
        .interior_tile (interior_tile),
        .left_tile     (left_tile),
        .right_tile    (right_tile),
        .last          (last)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for the disc span rasterizer
// Sends disc words through the start/busy handshake and checks every strobed
// span against a local rasterizer. Covers corners, map clipping, rounding,
// erase, fill tile extremes and random words under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
    import dsr_pkg::*;

    localparam int MAP_COLS      = 40;
    localparam int MAP_LINES     = 32;
    localparam int DISC_RADIUS   = 7;
    localparam int EDGE_CELL     = 2;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 1000;

    // one span as the block presents it
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  first_col;
        logic [COL_W-1:0]  last_col;
        logic [TILE_W-1:0] interior_tile;
        logic [TILE_W-1:0] left_tile;
        logic [TILE_W-1:0] right_tile;
        logic              last;
    } span_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               active;
    logic               cfg_we;
    logic [TILE_W-1:0]  cfg_wdata;
    logic               span_strobe;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   first_col;
    logic [COL_W-1:0]   last_col;
    logic [TILE_W-1:0]  interior_tile;
    logic [TILE_W-1:0]  left_tile;
    logic [TILE_W-1:0]  right_tile;
    logic               last;

    span_word_t        pending_spans[$];
    logic [TILE_W-1:0] fill_tile_copy;
    int                errors        = 0;
    int                words_sent    = 0;
    int                spans_checked = 0;
    int                cfg_writes    = 0;
    int                send_idle_pct = 0;
    int                stall_cycles  = 0;

    disc_span_rasterizer_top #(
        .MAP_COLUMNS (MAP_COLS),
        .MAP_ROWS    (MAP_LINES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .active        (active),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .span_strobe   (span_strobe),
        .row           (row),
        .first_col     (first_col),
        .last_col      (last_col),
        .interior_tile (interior_tile),
        .left_tile     (left_tile),
        .right_tile    (right_tile),
        .last          (last)
    );

    // free-running clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // half-width of the disc at a row distance from the centre
    function automatic int half_span(input int row_dist);
        case (row_dist)
            0, 1, 2, 3: return 7;
            4, 5:       return 6;
            6:          return 4;
            default:    return 3;
        endcase
    endfunction

    // rasterize one disc word and queue its spans in output order
    task automatic predict_disc_spans(
        input logic [POS_X_W-1:0] x,
        input logic [POS_Y_W-1:0] y,
        input logic               act
    );
        int                cx;
        int                cy;
        int                line;
        int                row_dist;
        int                lft;
        int                rgt;
        bit                lcut;
        bit                rcut;
        bit                have_prev;
        logic [TILE_W-1:0] fill;
        logic [TILE_W-1:0] rim;
        logic [TILE_W-1:0] body;
        span_word_t        s;
        span_word_t        prev;
        cx        = (int'(x) + 4) / 8;
        cy        = (int'(y) + 4) / 8;
        fill      = act ? fill_tile_copy : '0;
        rim       = act ? fill + 8'd1 : '0;
        have_prev = 1'b0;
        for (int d = -DISC_RADIUS; d <= DISC_RADIUS; d++)
        begin
            line = cy + d;
            row_dist = (d < 0) ? -d : d;
            // drop rows off the map
            if (line < EDGE_CELL || line >= MAP_LINES)
                continue;
            lft  = cx - half_span(row_dist);
            rgt  = cx + half_span(row_dist);
            lcut = lft < EDGE_CELL;
            rcut = rgt >= MAP_COLS;
            if (lcut)
                lft = EDGE_CELL;
            if (rcut)
                rgt = MAP_COLS - 1;
            // drop spans clipped away entirely
            if (rgt < lft)
                continue;
            // outermost rows are all rim; elsewhere only unclamped ends get rim
            body = (row_dist == DISC_RADIUS) ? rim : fill;
            s.row           = ROW_W'(line);
            s.first_col     = COL_W'(lft);
            s.last_col      = COL_W'(rgt);
            s.interior_tile = body;
            s.left_tile     = body;
            s.right_tile    = body;
            s.last          = 1'b0;
            if (body == fill)
            begin
                if (!lcut)
                    s.left_tile = rim;
                if (!rcut)
                    s.right_tile = rim;
            end
            if (have_prev)
                pending_spans.push_back(prev);
            prev      = s;
            have_prev = 1'b1;
        end
        // mark the final span of the word
        if (have_prev)
        begin
            prev.last = 1'b1;
            pending_spans.push_back(prev);
        end
    endtask

    // send one word, idling first at the current rate, and hold until taken
    task automatic send_word(
        input logic [POS_X_W-1:0] x,
        input logic [POS_Y_W-1:0] y,
        input logic               act
    );
        if ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        start  <= 1'b1;
        pos_x  <= x;
        pos_y  <= y;
        active <= act;
        do
            @(posedge clk);
        while (busy);
        predict_disc_spans(x, y, act);
        words_sent++;
    endtask

    // stop sending and wait until every queued span has come out
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the fill tile register; call only while the block is idle
    task automatic write_fill_tile(input logic [TILE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we         <= 1'b0;
        fill_tile_copy  = value;
        cfg_writes++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // compare each strobed span with the oldest pending one
    always @(posedge clk)
    begin : span_check
        span_word_t want;
        if (rst_n && span_strobe)
        begin
            spans_checked++;
            if (pending_spans.size() == 0)
            begin
                $error("span with none pending: row %0d cols %0d..%0d",
                       row, first_col, last_col);
                errors++;
            end
            else
            begin
                want = pending_spans.pop_front();
                check_field("row", want.row, row);
                check_field("first_col", want.first_col, first_col);
                check_field("last_col", want.last_col, last_col);
                check_field("interior_tile", want.interior_tile, interior_tile);
                check_field("left_tile", want.left_tile, left_tile);
                check_field("right_tile", want.right_tile, right_tile);
                check_field("last", want.last, last);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || span_strobe)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("disc_span_rasterizer_top regression: fail");
            $finish;
        end
    end

    // corners, rounding, clipping on every side and erase, at reset tile 0
    task automatic test_directed_geometry();
        send_idle_pct = 0;
        send_word(10'd156, 9'd124, 1'b1);   // full disc, no clipping
        send_word(10'd0, 9'd0, 1'b1);       // top-left corner
        send_word(10'd1023, 9'd511, 1'b1);  // far off the map: no span
        send_word(10'd3, 9'd3, 1'b1);       // rounds down to cell 0
        send_word(10'd4, 9'd4, 1'b1);       // rounds up to cell 1
        send_word(10'd308, 9'd124, 1'b1);   // right clamp at cell 39
        send_word(10'd332, 9'd124, 1'b1);   // one-cell outer rows
        send_word(10'd340, 9'd124, 1'b1);   // outer rows clipped empty
        send_word(10'd372, 9'd124, 1'b1);   // every row clipped empty
        send_word(10'd156, 9'd300, 1'b1);   // only the bottom map row
        send_word(10'd156, 9'd308, 1'b1);   // rows all below the map
        send_word(10'd156, 9'd4, 1'b1);     // top rows cut
        send_word(10'd156, 9'd188, 1'b1);   // reaches the last map row
        send_word(10'd156, 9'd124, 1'b0);   // erase
        send_word(10'd0, 9'd0, 1'b0);       // erase at the corner
        send_word(10'h2AA, 9'h155, 1'b1);
        send_word(10'h155, 9'h0AA, 1'b1);
        send_word(10'd1023, 9'd0, 1'b0);
        send_word(10'd0, 9'd511, 1'b1);
        wait_for_drain();
    endtask

    // fill tile extremes, including the rim wrap from 255 to 0
    task automatic test_fill_tile_extremes();
        logic [TILE_W-1:0] tiles[3];
        tiles = '{8'hFF, 8'h80, 8'h00};
        foreach (tiles[i])
        begin
            write_fill_tile(tiles[i]);
            send_word(10'd12, 9'd124, 1'b1);
            send_word(10'd156, 9'd124, 1'b1);
            wait_for_drain();
        end
    endtask

    // random words, mostly near the map, with one drain pause midway
    task automatic test_random_words(
        input int                idle_pct,
        input logic [TILE_W-1:0] tile,
        input int                count
    );
        logic [POS_X_W-1:0] x;
        logic [POS_Y_W-1:0] y;
        write_fill_tile(tile);
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_for_drain();
            if ($urandom_range(3) != 0)
            begin
                x = POS_X_W'($urandom_range(380));
                y = POS_Y_W'($urandom_range(320));
            end
            else
            begin
                x = POS_X_W'($urandom_range(1023));
                y = POS_Y_W'($urandom_range(511));
            end
            send_word(x, y, $urandom_range(9) != 0);
        end
        wait_for_drain();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        pos_x          <= '0;
        pos_y          <= '0;
        active         <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        fill_tile_copy  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_geometry();
        test_fill_tile_extremes();
        // the receiver cannot stall, so only the sender idles in each phase
        test_random_words(0, TILE_W'($urandom_range(255)), 100);
        test_random_words(64, 8'hFF, 100);
        test_random_words(0, TILE_W'($urandom_range(255)), 100);
        test_random_words(18, TILE_W'($urandom_range(255)), 100);

        wait_for_drain();
        $display("covered %0d disc words (clipping, rounding, erase, tiles 0..255)",
                 words_sent);
        $display("checked %0d spans across %0d fill tile writes", spans_checked,
                 cfg_writes);
        if (errors == 0)
            $display("disc_span_rasterizer_top regression: pass");
        else
            $display("disc_span_rasterizer_top regression: fail");
        $finish;
    end

endmodule
